// ===== sv/dct_pkg.sv =====
// shared types, constants and cosine table for the 8x8 dct unit
package dct_pkg;

    localparam int N          = 8;
    localparam int NN         = N * N;
    localparam int F          = 14;
    localparam int VAL_W      = 19;
    localparam int STORE_W    = 18;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int COS_W      = F + 2;
    // one product term: store x cos x (2*cos)
    localparam int PROD1_W    = STORE_W + COS_W + 1;
    localparam int PROD_W     = PROD1_W + COS_W + 1;
    localparam int ACC_W      = PROD_W + 7;

    localparam logic MODE_FWD = 1'b0;
    localparam logic MODE_INV = 1'b1;

    typedef enum logic [2:0] {
        t_ST_LOAD,
        t_ST_CLEAR,
        t_ST_MAC,
        t_ST_DRAIN,
        t_ST_EMIT
    } t_state;

    typedef struct packed {
        logic clr_acc;
        logic mac_en;
        logic mac_last;
        logic emit;
        logic inverse;
    } t_dct_cmd;

    typedef struct packed {
        logic res_valid;
        logic out_busy;
    } t_dct_sts;

    // cosine table C[k][n] in Q1.14, precomputed
    function automatic logic signed [COS_W-1:0] cos_tab(input logic [2:0] k,
                                                       input logic [2:0] n);
        logic signed [COS_W-1:0] t [0:63];
        t = '{
            16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384,
            16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384,
            16'sd16069, 16'sd13623, 16'sd9102, 16'sd3196,
            -16'sd3196, -16'sd9102, -16'sd13623, -16'sd16069,
            16'sd15137, 16'sd6270, -16'sd6270, -16'sd15137,
            -16'sd15137, -16'sd6270, 16'sd6270, 16'sd15137,
            16'sd13623, -16'sd3196, -16'sd16069, -16'sd9102,
            16'sd9102, 16'sd16069, 16'sd3196, -16'sd13623,
            16'sd11585, -16'sd11585, -16'sd11585, 16'sd11585,
            16'sd11585, -16'sd11585, -16'sd11585, 16'sd11585,
            16'sd9102, -16'sd16069, 16'sd3196, 16'sd13623,
            -16'sd13623, -16'sd3196, 16'sd16069, -16'sd9102,
            16'sd6270, -16'sd15137, 16'sd15137, -16'sd6270,
            -16'sd6270, 16'sd15137, -16'sd15137, 16'sd6270,
            16'sd3196, -16'sd9102, 16'sd13623, -16'sd16069,
            16'sd16069, -16'sd13623, 16'sd9102, -16'sd3196
        };
        return t[{k, n}];
    endfunction

endpackage

// ===== sv/dct_if.sv =====
// valid/ready channel interfaces for input and result items
interface dct_in_if;
    logic                   valid;
    logic                   ready;
    logic signed [18:0]     in_value;
    modport source (output valid, output in_value, input ready);
    modport sink   (input valid, input in_value, output ready);
endinterface

interface dct_out_if;
    logic                   valid;
    logic                   ready;
    logic signed [18:0]     out_value;
    logic [5:0]             out_index;
    logic                   out_last;
    modport source (output valid, output out_value, output out_index, output out_last,
                    input ready);
    modport sink   (input valid, input out_value, input out_index, input out_last,
                    output ready);
endinterface

// ===== sv/dct_ram.sv =====
// generic single-port-write, single-read ram with registered read
module dct_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/dct_ctrl.sv =====
// controller: sequences load, per-result mac sweep and emit
module dct_ctrl import dct_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_fire,
    input  logic              i_mode,
    input  t_dct_sts          i_sts,
    output logic              o_in_ready,
    output logic [IDX_W-1:0]  o_res_idx,
    output logic [IDX_W-1:0]  o_term_idx,
    output t_dct_cmd          o_cmd
);
    t_state r_state, n_state;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [IDX_W-1:0] r_res, n_res;
    logic [CNT_W-1:0] r_term, n_term;
    logic r_inv, n_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_ST_LOAD;
            r_fill  <= '0;
            r_res   <= '0;
            r_term  <= '0;
            r_inv   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_res   <= n_res;
            r_term  <= n_term;
            r_inv   <= n_inv;
        end
    end

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_res   = r_res;
        n_term  = r_term;
        n_inv   = r_inv;
        case (r_state)
            t_ST_LOAD: begin
                if (i_in_fire) begin
                    if (r_fill == CNT_W'(NN - 1)) begin
                        n_fill  = '0;
                        n_res   = '0;
                        n_inv   = (i_mode == MODE_INV);
                        n_state = t_ST_CLEAR;
                    end else begin
                        n_fill = r_fill + 1'b1;
                    end
                end
            end
            t_ST_CLEAR: begin
                n_term  = '0;
                n_state = t_ST_MAC;
            end
            t_ST_MAC: begin
                n_term = r_term + 1'b1;
                if (r_term == CNT_W'(NN - 1)) begin
                    n_state = t_ST_DRAIN;
                end
            end
            t_ST_DRAIN: begin
                if (i_sts.res_valid) begin
                    n_state = t_ST_EMIT;
                end
            end
            t_ST_EMIT: begin
                if (!i_sts.out_busy) begin
                    if (r_res == IDX_W'(NN - 1)) begin
                        n_state = t_ST_LOAD;
                    end else begin
                        n_res   = r_res + 1'b1;
                        n_state = t_ST_CLEAR;
                    end
                end
            end
            default: n_state = t_ST_LOAD;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.inverse  = r_inv;
        o_in_ready     = 1'b0;
        case (r_state)
            t_ST_LOAD:  o_in_ready = 1'b1;
            t_ST_CLEAR: o_cmd.clr_acc = 1'b1;
            t_ST_MAC: begin
                o_cmd.mac_en   = 1'b1;
                o_cmd.mac_last = (r_term == CNT_W'(NN - 1));
            end
            t_ST_EMIT:  o_cmd.emit = !i_sts.out_busy;
            default:    o_in_ready = 1'b0;
        endcase
    end

    assign o_res_idx  = r_res;
    assign o_term_idx = (r_state == t_ST_LOAD) ? r_fill[IDX_W-1:0] : r_term[IDX_W-1:0];
endmodule

// ===== sv/dct_dp.sv =====
// datapath: block store, pipelined multiply-accumulate, rounding and output register
module dct_dp import dct_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_fire,
    input  logic signed [VAL_W-1:0] i_in_value,
    input  logic [IDX_W-1:0]        i_res_idx,
    input  logic [IDX_W-1:0]        i_term_idx,
    input  t_dct_cmd                i_cmd,
    input  logic                    i_out_ready,
    output t_dct_sts                o_sts,
    output logic                    o_out_valid,
    output logic signed [VAL_W-1:0] o_out_value,
    output logic [IDX_W-1:0]        o_out_index,
    output logic                    o_out_last
);
    logic signed [STORE_W-1:0] w_sat_in;
    logic [STORE_W-1:0]        w_rdata;

    always_comb begin
        if (i_in_value > VAL_W'(131071))
            w_sat_in = STORE_W'(131071);
        else if (i_in_value < -VAL_W'(131072))
            w_sat_in = -STORE_W'(131072);
        else
            w_sat_in = i_in_value[STORE_W-1:0];
    end

    dct_ram #(.WIDTH(STORE_W), .DEPTH(NN)) u_store (
        .i_clk   (i_clk),
        .i_we    (i_in_fire),
        .i_waddr (i_term_idx),
        .i_wdata (w_sat_in),
        .i_raddr (i_term_idx),
        .o_rdata (w_rdata)
    );

    // stage 1: pick cosine factors while the ram read completes
    logic               r_v1, r_l1;
    logic signed [COS_W:0] r_ca, r_cb;
    logic [2:0] w_r, w_c, w_a, w_b;
    logic signed [COS_W:0] w_ca, w_cb;
    assign w_r = i_res_idx[5:3];
    assign w_c = i_res_idx[2:0];
    assign w_a = i_term_idx[5:3];
    assign w_b = i_term_idx[2:0];
    always_comb begin
        if (i_cmd.inverse) begin
            w_ca = (w_a == 3'd0) ? (COS_W+1)'(cos_tab(w_a, w_r))
                                 : (COS_W+1)'(cos_tab(w_a, w_r)) <<< 1;
            w_cb = (w_b == 3'd0) ? (COS_W+1)'(cos_tab(w_b, w_c))
                                 : (COS_W+1)'(cos_tab(w_b, w_c)) <<< 1;
        end else begin
            w_ca = (COS_W+1)'(cos_tab(w_r, w_a));
            w_cb = (COS_W+1)'(cos_tab(w_c, w_b));
        end
    end

    // stage 2: sample x cos_a; stage 3: x cos_b; stage 4: accumulate
    logic signed [PROD1_W-1:0] r_p1;
    logic signed [COS_W:0]     r_cb2;
    logic                      r_v2, r_l2;
    logic signed [PROD_W-1:0]  r_p2;
    logic                      r_v3, r_l3;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_done;

    always_ff @(posedge i_clk) begin
        r_ca  <= w_ca;
        r_cb  <= w_cb;
        r_p1  <= PROD1_W'($signed(w_rdata) * r_ca);
        r_cb2 <= r_cb;
        r_p2  <= PROD_W'(r_p1 * r_cb2);
        if (i_cmd.clr_acc) begin
            r_acc <= '0;
        end else if (r_v3) begin
            r_acc <= r_acc + ACC_W'(r_p2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_l1 <= 1'b0;
            r_v2 <= 1'b0; r_l2 <= 1'b0;
            r_v3 <= 1'b0; r_l3 <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1 <= i_cmd.mac_en; r_l1 <= i_cmd.mac_last;
            r_v2 <= r_v1;         r_l2 <= r_l1;
            r_v3 <= r_v2;         r_l3 <= r_l2;
            if (i_cmd.clr_acc || i_cmd.emit)
                r_done <= 1'b0;
            else if (r_v3 && r_l3)
                r_done <= 1'b1;
        end
    end

    // rounding: ties away from zero; inverse also divides by 64
    logic [ACC_W-1:0]        w_mag;
    logic [ACC_W-1:0]        w_q;
    logic signed [ACC_W-1:0] w_res;
    logic signed [VAL_W-1:0] w_final;
    always_comb begin
        w_mag = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
        if (i_cmd.inverse)
            w_q = (w_mag + (ACC_W'(1) << (2*F + 5))) >> (2*F + 6);
        else
            w_q = (w_mag + (ACC_W'(1) << (2*F - 1))) >> (2*F);
        w_res = r_acc[ACC_W-1] ? -$signed(w_q) : $signed(w_q);
        if (i_cmd.inverse) begin
            if (w_res > ACC_W'(2047))       w_final = VAL_W'(2047);
            else if (w_res < -ACC_W'(2048)) w_final = -VAL_W'(2048);
            else                            w_final = w_res[VAL_W-1:0];
        end else begin
            if (w_res > ACC_W'(131072))       w_final = VAL_W'(131072);
            else if (w_res < -ACC_W'(131072)) w_final = -VAL_W'(131072);
            else                              w_final = w_res[VAL_W-1:0];
        end
    end

    logic r_ov;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_out_value <= w_final;
            o_out_index <= i_res_idx;
            o_out_last  <= (i_res_idx == IDX_W'(NN - 1));
        end
    end

    assign o_out_valid     = r_ov;
    assign o_sts.res_valid = r_done;
    assign o_sts.out_busy  = r_ov && !i_out_ready;
endmodule

// ===== sv/dct_2d_8x8_fwd_inv_unit.sv =====
// 8x8 forward/inverse dct: 64 items in, then 64 results each from a 64-term mac sweep
// per result: clear the accumulator, run the 64-term mac sweep, drain the mac pipeline
// and emit into the output register; every result uses the one shared mac, and no new
// block is taken until the last result of the block is emitted;
// a result waits in the output register, a stalled output adds its wait to the next emit
// reset: synchronous active low; clears control, mode to forward; store is not cleared
module dct_2d_8x8_fwd_inv_unit import dct_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [0:0]   i_cfg_wdata,
    dct_in_if.sink       i_in,
    dct_out_if.source    o_out
);
    logic r_mode;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mode <= MODE_FWD;
        else if (i_cfg_we) r_mode <= i_cfg_wdata[0];
    end

    logic w_ready, w_fire;
    logic [IDX_W-1:0] w_res, w_term;
    t_dct_cmd w_cmd;
    t_dct_sts w_sts;
    assign i_in.ready = w_ready;
    assign w_fire     = i_in.valid && w_ready;

    dct_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(w_fire), .i_mode(r_mode),
        .i_sts(w_sts), .o_in_ready(w_ready), .o_res_idx(w_res),
        .o_term_idx(w_term), .o_cmd(w_cmd)
    );

    dct_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(w_fire),
        .i_in_value(i_in.in_value), .i_res_idx(w_res), .i_term_idx(w_term),
        .i_cmd(w_cmd), .i_out_ready(o_out.ready), .o_sts(w_sts),
        .o_out_valid(o_out.valid), .o_out_value(o_out.out_value),
        .o_out_index(o_out.out_index), .o_out_last(o_out.out_last)
    );
endmodule

// ===== sv/dct_checker.sv =====
// port-level checker for the dct unit, bound to the top level
module dct_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [5:0]  i_out_index,
    input logic        i_out_last
);
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_last == (i_out_index == 6'd63)))
        else $error("last flag mismatch");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_index))
        else $error("result dropped under stall");
    a_no_load_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready |-> !i_out_valid || i_out_index == 6'd63)
        else $error("input taken while block results pending");
    // the last result may be loaded at the edge that takes the one before it
    a_next_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=> !i_in_ready || (i_out_valid && i_out_last))
        else $error("input ready mid-block output");
endmodule

bind dct_2d_8x8_fwd_inv_unit dct_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(i_in.valid), .i_in_ready(i_in.ready),
    .i_out_valid(o_out.valid), .i_out_ready(o_out.ready),
    .i_out_index(o_out.out_index), .i_out_last(o_out.out_last)
);
